FILE: rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Byte codes, register indexes, status codes and the parse state record.
// ----------------------------------------------------------------------------
package efd_pkg;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] END_BYTE   = 8'h7F;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_START  = 8'h5E;
	localparam logic [7:0] ESC_END    = 8'h5F;
	localparam logic [7:0] ESC_ESC    = 8'h5D;

	localparam int unsigned LEN_W     = 4;
	localparam int unsigned KEEP_N    = 4;

	localparam logic [LEN_W-1:0] MIN_LEN_RESET = 4'd6;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 4'd9;

	typedef enum logic [0:0] {
		REG_MIN_LEN = 1'b0,
		REG_MAX_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEN  = 3'd1,
		ST_BAD_DELIM = 3'd2,
		ST_BAD_ESC  = 3'd3,
		ST_BAD_SUM  = 3'd4
	} status_t;

	typedef struct packed {
		logic                          esc_pend;
		logic                          esc_err;
		logic [LEN_W-1:0]              pcnt;
		logic [KEEP_N-1:0][7:0]        pbytes;
	} parse_t;

endpackage

FILE: rtl/efd_in_if.sv
// ----------------------------------------------------------------------------
// efd_in_if: received byte channel
// Carries one raw byte and the end of frame flag per word.
// ----------------------------------------------------------------------------
interface efd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

FILE: rtl/efd_out_if.sv
// ----------------------------------------------------------------------------
// efd_out_if: frame result channel
// Carries one status word with the first four payload bytes per frame.
// ----------------------------------------------------------------------------
interface efd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] frame_status;
	logic [7:0] op_byte;
	logic [7:0] arg_byte;
	logic [7:0] third_byte;
	logic [7:0] check_byte;
	logic [3:0] payload_count;

	modport source (output valid, output frame_status, output op_byte, output arg_byte,
		output third_byte, output check_byte, output payload_count, input ready);
	modport sink (input valid, input frame_status, input op_byte, input arg_byte,
		input third_byte, input check_byte, input payload_count, output ready);
endinterface

FILE: rtl/escaped_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// escaped_frame_deframer_checker: byte stuffed frame deframer and checker
// A frame's last byte passes the input register, then the result register.
// Throughput: one byte per cycle, save that an end byte waits while the
// result register holds an untaken result; the next frame streams in
// meanwhile. Reset clears all frame state and loads the length registers
// with 6 and 9; payload byte storage is not reset.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_checker
	import efd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [0:0]       wr_idx,
	input  logic [LEN_W-1:0] wr_data,
	efd_in_if.sink           byte_in,
	efd_out_if.source        result
);

	logic [LEN_W-1:0] min_len_q, max_len_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic [LEN_W-1:0] raw_count_q;
	logic             first_start_q;
	logic [7:0]       held_byte_q;
	logic             held_valid_q;
	logic             esc_pend_q, esc_err_q;
	logic [LEN_W-1:0] pcnt_q;
	logic [KEEP_N-1:0][7:0] pbytes_q;

	logic       out_valid_q;
	logic [2:0] status_q;
	logic [KEEP_N-1:0][7:0] obytes_q;
	logic [3:0] ocount_q;

	logic       advance;
	logic       emit;
	parse_t     cur, nxt;
	logic       err_final;
	logic       first_ok, last_ok;
	logic [LEN_W:0] len;
	logic [7:0] sum;
	status_t    status;
	logic       keep_fields;
	logic [KEEP_N-1:0][7:0] obytes_d;

	function automatic parse_t take_inner(parse_t st, logic [7:0] b);
		parse_t r;
		logic [7:0] v;
		logic st_en;
		r     = st;
		v     = b;
		st_en = 1'b0;
		if (!st.esc_err) begin
			if (st.esc_pend) begin
				r.esc_pend = 1'b0;
				case (b)
					ESC_START: begin v = START_BYTE; st_en = 1'b1; end
					ESC_END:   begin v = END_BYTE;   st_en = 1'b1; end
					ESC_ESC:   begin v = ESC_BYTE;   st_en = 1'b1; end
					default:   r.esc_err = 1'b1;
				endcase
			end else if (b == ESC_BYTE) begin
				r.esc_pend = 1'b1;
			end else begin
				st_en = 1'b1;
			end
		end
		if (st_en) begin
			if (st.pcnt < LEN_W'(KEEP_N))
				r.pbytes[st.pcnt[1:0]] = v;
			if (st.pcnt != {LEN_W{1'b1}})
				r.pcnt = st.pcnt + 1'b1;
		end
		return r;
	endfunction

	assign advance      = valid_s1 && (!end_s1 || !out_valid_q || result.ready);
	assign emit         = advance && end_s1;
	assign byte_in.ready = !valid_s1 || advance;

	always_comb begin
		cur.esc_pend = esc_pend_q;
		cur.esc_err  = esc_err_q;
		cur.pcnt     = pcnt_q;
		cur.pbytes   = pbytes_q;
		nxt = cur;
		if (raw_count_q != '0 && held_valid_q)
			nxt = take_inner(cur, held_byte_q);

		err_final = nxt.esc_err || nxt.esc_pend;
		first_ok  = (raw_count_q == '0) ? (byte_s1 == START_BYTE) : first_start_q;
		last_ok   = byte_s1 == END_BYTE;
		len       = {1'b0, raw_count_q} + 1'b1;
		sum       = nxt.pbytes[0] + nxt.pbytes[1] + nxt.pbytes[2];

		if (len < {1'b0, min_len_q} || len > {1'b0, max_len_q})
			status = ST_BAD_LEN;
		else if (!first_ok || !last_ok)
			status = ST_BAD_DELIM;
		else if (err_final)
			status = ST_BAD_ESC;
		else if (nxt.pcnt < LEN_W'(KEEP_N) || nxt.pbytes[3] != sum)
			status = ST_BAD_SUM;
		else
			status = ST_OK;

		keep_fields = (status == ST_OK) || (status == ST_BAD_SUM);
		for (int i = 0; i < KEEP_N; i++)
			obytes_d[i] = (keep_fields && nxt.pcnt > LEN_W'(i)) ? nxt.pbytes[i] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_idx))
				REG_MIN_LEN: min_len_q <= wr_data;
				REG_MAX_LEN: max_len_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_in.ready)
			valid_s1 <= byte_in.valid;
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.rx_byte;
			end_s1  <= byte_in.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q   <= '0;
			first_start_q <= 1'b0;
			held_byte_q   <= 8'h00;
			held_valid_q  <= 1'b0;
			esc_pend_q    <= 1'b0;
			esc_err_q     <= 1'b0;
			pcnt_q        <= '0;
		end else if (advance) begin
			if (end_s1) begin
				raw_count_q   <= '0;
				first_start_q <= 1'b0;
				held_byte_q   <= 8'h00;
				held_valid_q  <= 1'b0;
				esc_pend_q    <= 1'b0;
				esc_err_q     <= 1'b0;
				pcnt_q        <= '0;
			end else begin
				if (raw_count_q == '0) begin
					first_start_q <= byte_s1 == START_BYTE;
				end else begin
					held_byte_q  <= byte_s1;
					held_valid_q <= 1'b1;
				end
				if (raw_count_q != {LEN_W{1'b1}})
					raw_count_q <= raw_count_q + 1'b1;
				esc_pend_q <= nxt.esc_pend;
				esc_err_q  <= nxt.esc_err;
				pcnt_q     <= nxt.pcnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !end_s1)
			pbytes_q <= nxt.pbytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= status;
			obytes_q <= obytes_d;
			ocount_q <= keep_fields ? nxt.pcnt : 4'd0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.frame_status  = status_q;
	assign result.op_byte       = obytes_q[0];
	assign result.arg_byte      = obytes_q[1];
	assign result.third_byte    = obytes_q[2];
	assign result.check_byte    = obytes_q[3];
	assign result.payload_count = ocount_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the escaped frame deframer and checker
// Streams raw byte frames into the block: directed frames for each status and
// corner case, then random well-formed, broken and noise frames under several
// length settings and idle patterns. A local model of the deframer predicts
// one result word per frame; a monitor compares every accepted result word.
// ----------------------------------------------------------------------------
module tb
	import efd_pkg::*;
();

	typedef logic [7:0] bytes_t[$];

	typedef struct packed {
		status_t    status;
		logic [7:0] op_byte;
		logic [7:0] arg_byte;
		logic [7:0] third_byte;
		logic [7:0] check_byte;
		logic [3:0] payload_count;
	} frame_result_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [0:0]       wr_idx;
	logic [LEN_W-1:0] wr_data;

	efd_in_if  byte_in();
	efd_out_if result();

	escaped_frame_deframer_checker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.byte_in (byte_in),
		.result  (result)
	);

	// length registers as the block should hold them
	logic [3:0] min_len;
	logic [3:0] max_len;

	// frame parse state of the local model
	logic [3:0] raw_cnt;
	logic       head_was_start;
	logic [7:0] held_byte;
	logic       held_valid;
	logic       esc_pending;
	logic       esc_error;
	logic [7:0] kept_bytes[KEEP_N];
	logic [3:0] payload_cnt;

	frame_result_t expected_frames[$];
	int            mismatches;
	int            bytes_sent;
	int            src_idle_pct;
	int            sink_stall_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("escaped_frame_deframer_checker verification failed");
		$finish;
	end

	function automatic void clear_frame();
		raw_cnt        = '0;
		head_was_start = 1'b0;
		held_byte      = '0;
		held_valid     = 1'b0;
		esc_pending    = 1'b0;
		esc_error      = 1'b0;
		payload_cnt    = '0;
		foreach (kept_bytes[i])
			kept_bytes[i] = '0;
	endfunction

	function automatic void keep_payload(logic [7:0] b);
		if (payload_cnt < KEEP_N)
			kept_bytes[payload_cnt] = b;
		if (payload_cnt != 4'd15)
			payload_cnt++;
	endfunction

	function automatic void unstuff_byte(logic [7:0] b);
		if (esc_error)
			return;
		if (esc_pending) begin
			esc_pending = 1'b0;
			case (b)
				ESC_START: keep_payload(START_BYTE);
				ESC_END:   keep_payload(END_BYTE);
				ESC_ESC:   keep_payload(ESC_BYTE);
				default:   esc_error = 1'b1;
			endcase
		end else if (b == ESC_BYTE) begin
			esc_pending = 1'b1;
		end else begin
			keep_payload(b);
		end
	endfunction

	function automatic void deframe_byte(logic [7:0] b, logic last);
		int            flen;
		logic          head_ok;
		logic          tail_ok;
		logic [7:0]    sum;
		frame_result_t r;
		if (!last) begin
			if (raw_cnt == 0) begin
				head_was_start = (b == START_BYTE);
			end else begin
				if (held_valid)
					unstuff_byte(held_byte);
				held_byte  = b;
				held_valid = 1'b1;
			end
			if (raw_cnt != 4'd15)
				raw_cnt++;
			return;
		end
		flen = int'(raw_cnt) + 1;
		if (raw_cnt == 0) begin
			head_ok = (b == START_BYTE);
		end else begin
			if (held_valid)
				unstuff_byte(held_byte);
			head_ok = head_was_start;
		end
		tail_ok = (b == END_BYTE);
		if (esc_pending)
			esc_error = 1'b1;
		sum = kept_bytes[0] + kept_bytes[1] + kept_bytes[2];
		r = '0;
		if (flen < int'(min_len) || flen > int'(max_len))
			r.status = ST_BAD_LEN;
		else if (!head_ok || !tail_ok)
			r.status = ST_BAD_DELIM;
		else if (esc_error)
			r.status = ST_BAD_ESC;
		else if (payload_cnt < KEEP_N || kept_bytes[3] != sum)
			r.status = ST_BAD_SUM;
		else
			r.status = ST_OK;
		if (r.status == ST_OK || r.status == ST_BAD_SUM) begin
			r.op_byte       = (payload_cnt > 0) ? kept_bytes[0] : 8'h00;
			r.arg_byte      = (payload_cnt > 1) ? kept_bytes[1] : 8'h00;
			r.third_byte    = (payload_cnt > 2) ? kept_bytes[2] : 8'h00;
			r.check_byte    = (payload_cnt > 3) ? kept_bytes[3] : 8'h00;
			r.payload_count = payload_cnt;
		end
		expected_frames.push_back(r);
		clear_frame();
	endfunction

	function automatic void check_result();
		frame_result_t got;
		frame_result_t want;
		got.status        = status_t'(result.frame_status);
		got.op_byte       = result.op_byte;
		got.arg_byte      = result.arg_byte;
		got.third_byte    = result.third_byte;
		got.check_byte    = result.check_byte;
		got.payload_count = result.payload_count;
		if (expected_frames.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word: st=%0d op=%h arg=%h b3=%h chk=%h cnt=%0d",
					got.status, got.op_byte, got.arg_byte, got.third_byte,
					got.check_byte, got.payload_count);
			return;
		end
		want = expected_frames.pop_front();
		if (got.status !== want.status || got.op_byte !== want.op_byte ||
			got.arg_byte !== want.arg_byte || got.third_byte !== want.third_byte ||
			got.check_byte !== want.check_byte ||
			got.payload_count !== want.payload_count) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result mismatch: expected st=%0d op=%h arg=%h b3=%h chk=%h cnt=%0d",
					want.status, want.op_byte, want.arg_byte, want.third_byte,
					want.check_byte, want.payload_count);
				$display("                 actual   st=%0d op=%h arg=%h b3=%h chk=%h cnt=%0d",
					got.status, got.op_byte, got.arg_byte, got.third_byte,
					got.check_byte, got.payload_count);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (result.valid === 1'b1 && result.ready === 1'b1)
			check_result();
		result.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(11))
			0:       return START_BYTE;
			1:       return END_BYTE;
			2:       return ESC_BYTE;
			3:       return ESC_START;
			4:       return ESC_END;
			5:       return ESC_ESC;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic bytes_t stuff_frame(bytes_t payload);
		bytes_t f;
		f.push_back(START_BYTE);
		foreach (payload[i]) begin
			case (payload[i])
				START_BYTE: begin
					f.push_back(ESC_BYTE);
					f.push_back(ESC_START);
				end
				END_BYTE: begin
					f.push_back(ESC_BYTE);
					f.push_back(ESC_END);
				end
				ESC_BYTE: begin
					f.push_back(ESC_BYTE);
					f.push_back(ESC_ESC);
				end
				default: f.push_back(payload[i]);
			endcase
		end
		f.push_back(END_BYTE);
		return f;
	endfunction

	function automatic bytes_t make_random_frame();
		bytes_t pl;
		bytes_t f;
		int     kind;
		int     lo;
		int     hi;
		int     n;
		kind = $urandom_range(99);
		if (kind >= 85) begin
			n = $urandom_range(18, 1);
			repeat (n) f.push_back(rand_byte());
			return f;
		end
		lo = (min_len > 2) ? int'(min_len) - 2 : 0;
		hi = (max_len > 2) ? int'(max_len) - 2 : 0;
		if (hi < lo)
			hi = lo;
		n = ($urandom_range(4) == 0) ? $urandom_range(13) : $urandom_range(hi, lo);
		repeat (n) pl.push_back(rand_byte());
		if (n >= 4 && $urandom_range(4) != 0)
			pl[3] = pl[0] + pl[1] + pl[2];
		f = stuff_frame(pl);
		// corrupt one byte of a broken frame
		if (kind >= 70)
			f[$urandom_range(f.size() - 1)] = rand_byte();
		return f;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid     <= 1'b1;
		byte_in.rx_byte   <= b;
		byte_in.frame_end <= last;
		do
			@(posedge clk);
		while (byte_in.ready !== 1'b1);
		deframe_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame(input bytes_t f);
		foreach (f[i])
			send_byte(f[i], i == f.size() - 1);
	endtask

	task automatic wait_idle();
		byte_in.valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_lengths(input logic [3:0] lo_len, input logic [3:0] hi_len);
		wait_idle();
		wr_en   <= 1'b1;
		wr_idx  <= REG_MIN_LEN;
		wr_data <= lo_len;
		@(posedge clk);
		min_len = lo_len;
		wr_idx  <= REG_MAX_LEN;
		wr_data <= hi_len;
		@(posedge clk);
		max_len = hi_len;
		wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_valid_frames();
		bytes_t pl;
		send_frame(stuff_frame('{8'h11, 8'h22, 8'h33, 8'h66}));
		send_frame(stuff_frame('{START_BYTE, END_BYTE, ESC_BYTE, 8'h7A}));
		send_frame(stuff_frame('{8'h00, 8'hFF, 8'hFF, 8'hFE}));
		send_frame(stuff_frame('{8'h01, 8'h02, 8'h03, 8'h06, 8'hAA, 8'hBB, 8'hCC}));
		// raw delimiters inside a frame are plain data
		send_frame('{START_BYTE, START_BYTE, END_BYTE, 8'h01, 8'hFE, END_BYTE});
		pl = '{8'h01, 8'h02, 8'h03, 8'h06};
		repeat (3) pl.push_back(8'h44);
		send_frame(stuff_frame(pl));
	endtask

	task automatic test_frame_errors();
		send_frame(stuff_frame('{8'h01, 8'h02, 8'h03, 8'h07}));
		send_frame('{START_BYTE, ESC_BYTE, 8'h41, 8'h01, 8'h02, 8'h03, END_BYTE});
		// escape with no follower before the closing byte
		send_frame('{START_BYTE, 8'h01, 8'h02, 8'h03, 8'h06, ESC_BYTE, END_BYTE});
		send_frame('{8'h00, 8'h01, 8'h02, 8'h03, 8'h06, END_BYTE});
		send_frame('{START_BYTE, 8'h01, 8'h02, 8'h03, 8'h06, START_BYTE});
	endtask

	task automatic test_length_limits();
		bytes_t pl;
		send_frame(stuff_frame('{8'h01, 8'h02}));
		repeat (18) pl.push_back(8'h11);
		send_frame(stuff_frame(pl));
		send_frame('{START_BYTE});
		set_lengths(4'd0, 4'd15);
		send_frame('{START_BYTE});
		send_frame('{END_BYTE});
		send_frame('{START_BYTE, END_BYTE});
		send_frame(stuff_frame('{8'h5A}));
		send_frame(stuff_frame('{8'h01, 8'h02, 8'h03}));
		pl = '{8'h01, 8'h02, 8'h03, 8'h06};
		repeat (9) pl.push_back(8'h44);
		send_frame(stuff_frame(pl));
		pl.push_back(8'h44);
		send_frame(stuff_frame(pl));
	endtask

	task automatic test_odd_lengths();
		set_lengths(4'd12, 4'd4);
		send_frame(stuff_frame('{8'h01, 8'h02, 8'h03, 8'h06}));
		set_lengths(4'd3, 4'd3);
		send_frame('{START_BYTE, 8'h01, END_BYTE});
		send_frame('{START_BYTE, ESC_BYTE, END_BYTE});
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input logic [3:0] lo_len, input logic [3:0] hi_len, input int n_bytes);
		int first;
		set_lengths(lo_len, hi_len);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes)
			send_frame(make_random_frame());
	endtask

	initial begin
		int lo;
		clk               = 1'b0;
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_idx            = REG_MIN_LEN;
		wr_data           = '0;
		byte_in.valid     = 1'b0;
		byte_in.rx_byte   = '0;
		byte_in.frame_end = 1'b0;
		result.ready      = 1'b0;
		mismatches        = 0;
		bytes_sent        = 0;
		src_idle_pct      = 0;
		sink_stall_pct    = 0;
		min_len           = MIN_LEN_RESET;
		max_len           = MAX_LEN_RESET;
		clear_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_valid_frames();
		test_frame_errors();
		test_length_limits();
		test_odd_lengths();
		test_random_traffic(0, 0, 4'd3, 4'd15, 160);
		test_random_traffic(79, 0, 4'd6, 4'd9, 160);
		lo = $urandom_range(10, 3);
		test_random_traffic(0, 79, 4'(lo), 4'($urandom_range(15, lo)), 160);
		test_random_traffic(33, 33, 4'd4, 4'd12, 160);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("escaped_frame_deframer_checker verification clean");
		else
			$display("escaped_frame_deframer_checker verification failed");
		$finish;
	end

endmodule
